[hw/rtl/slte_pkg.sv]
// ---------------------------------------------------------------------------
// Status line time extractor package
// Shared widths, the captured-digit record and the queue transfer type.
// ---------------------------------------------------------------------------
package slte_pkg;

   localparam int NUM_DIGITS = 12;

   localparam int BYTE_W      = 8;
   localparam int SECONDS_W   = 13;
   localparam int HUNDREDTH_W = 7;
   localparam int TMIN_W      = 8;
   localparam int TSEC_W      = 6;
   localparam int MEDIA_W     = 20;

   // Twelve decimal digits of one capture, in the order they arrive.
   typedef struct packed {
      logic [NUM_DIGITS-1:0][3:0] digits;
      logic                       all_digits;
      logic                       seq_run;
   } rec_type;

   typedef struct packed {
      logic    valid;
      rec_type rec;
   } rec_xfer_type;

endpackage

[hw/rtl/slte_if.sv]
// ---------------------------------------------------------------------------
// Status line time extractor channels
// Valid/ready channels for status bytes, time results and the mode register.
// ---------------------------------------------------------------------------
interface slte_req_if import slte_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_of_chunk;
   logic              sequence_running;

   modport source (output valid, data_byte, last_of_chunk, sequence_running, input ready);
   modport sink (input valid, data_byte, last_of_chunk, sequence_running, output ready);
endinterface

interface slte_rsp_if import slte_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SECONDS_W-1:0]   elapsed_seconds;
   logic [HUNDREDTH_W-1:0] elapsed_hundredths;
   logic [SECONDS_W-1:0]   remaining_seconds;
   logic [HUNDREDTH_W-1:0] remaining_hundredths;
   logic [TMIN_W-1:0]      total_minutes;
   logic [TSEC_W-1:0]      total_seconds;
   logic [MEDIA_W-1:0]     media_time_hundredths;
   logic                   send_sync;
   logic                   adjust_delay;
   logic                   digits_ok;

   modport source (
      output valid, elapsed_seconds, elapsed_hundredths, remaining_seconds,
             remaining_hundredths, total_minutes, total_seconds,
             media_time_hundredths, send_sync, adjust_delay, digits_ok,
      input  ready
   );
   modport sink (
      input  valid, elapsed_seconds, elapsed_hundredths, remaining_seconds,
             remaining_hundredths, total_minutes, total_seconds,
             media_time_hundredths, send_sync, adjust_delay, digits_ok,
      output ready
   );
endinterface

interface slte_csr_if ();
   logic valid;
   logic ready;
   logic sync_leader;

   modport source (output valid, sync_leader, input ready);
   modport sink (input valid, sync_leader, output ready);
endinterface

[hw/rtl/slte_front.sv]
// ---------------------------------------------------------------------------
// Status line time extractor front end
// Keyword matcher and capture of the twelve digit positions after "Time:".
// ---------------------------------------------------------------------------
module slte_front import slte_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              last_of_chunk,
   input  logic              sequence_running,
   output rec_xfer_type      push
);

   localparam logic [BYTE_W-1:0] CHAR_T     = 8'h54;
   localparam logic [BYTE_W-1:0] CHAR_I     = 8'h69;
   localparam logic [BYTE_W-1:0] CHAR_M     = 8'h6D;
   localparam logic [BYTE_W-1:0] CHAR_E     = 8'h65;
   localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   localparam logic [4:0] LAST_POS = 5'd18;
   localparam logic [4:0] IDX_SAT  = 5'd20;

   typedef enum logic [6:0] {
      PH_IDLE    = 7'b0000001,
      PH_T       = 7'b0000010,
      PH_TI      = 7'b0000100,
      PH_TIM     = 7'b0001000,
      PH_TIME    = 7'b0010000,
      PH_COLON   = 7'b0100000,
      PH_CAPTURE = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] slot;
   } slot_type;

   // Digit positions of " mm:ss.cc [mm:ss.cc" mapped to digit slots.
   function automatic slot_type slot_of(input logic [4:0] pos);
      slot_type s;
      s.hit = 1'b1;
      unique case (pos)
         5'd1:    s.slot = 4'd0;
         5'd2:    s.slot = 4'd1;
         5'd4:    s.slot = 4'd2;
         5'd5:    s.slot = 4'd3;
         5'd7:    s.slot = 4'd4;
         5'd8:    s.slot = 4'd5;
         5'd11:   s.slot = 4'd6;
         5'd12:   s.slot = 4'd7;
         5'd14:   s.slot = 4'd8;
         5'd15:   s.slot = 4'd9;
         5'd17:   s.slot = 4'd10;
         5'd18:   s.slot = 4'd11;
         default: begin
            s.hit  = 1'b0;
            s.slot = 4'd0;
         end
      endcase
      return s;
   endfunction

   phase_type                  phase_ff, phase_in;
   logic [4:0]                 idx_ff, idx_in, idx_eff;
   logic [NUM_DIGITS-1:0][3:0] digit_ff;
   logic [NUM_DIGITS-1:0]      bad_ff;
   logic                       store, done, is_digit;
   logic [3:0]                 digit_val;
   slot_type                   wr_slot;

   assign is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
   assign digit_val = is_digit ? data_byte[3:0] : 4'd0;
   assign wr_slot   = slot_of(idx_eff);

   always_comb begin
      phase_in = phase_ff;
      idx_eff  = idx_ff;
      store    = 1'b0;
      done     = 1'b0;
      unique case (data_byte)
         CHAR_T:     phase_in = PH_T;
         CHAR_I:     phase_in = (phase_ff == PH_T) ? PH_TI : PH_IDLE;
         CHAR_M:     phase_in = (phase_ff == PH_TI) ? PH_TIM : PH_IDLE;
         CHAR_E:     phase_in = (phase_ff == PH_TIM) ? PH_TIME : PH_IDLE;
         CHAR_COLON: begin
            if (phase_ff == PH_TIME) begin
               phase_in = PH_COLON;
            end else if (idx_ff != 5'd0) begin
               store = 1'b1;
            end
         end
         default: begin
            if (phase_ff == PH_COLON) begin
               idx_eff  = 5'd0;
               phase_in = PH_CAPTURE;
            end
            if (phase_ff == PH_COLON || phase_ff == PH_CAPTURE) begin
               store = 1'b1;
               done  = (idx_eff == LAST_POS);
            end
         end
      endcase

      idx_in = idx_eff;
      if (store) begin
         idx_in = (idx_eff == IDX_SAT) ? IDX_SAT : idx_eff + 5'd1;
      end
      if (done) begin
         idx_in   = 5'd0;
         phase_in = PH_IDLE;
      end
      if (last_of_chunk) begin
         idx_in   = 5'd0;
         phase_in = PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         idx_ff   <= 5'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store && wr_slot.hit) begin
         digit_ff[wr_slot.slot] <= digit_val;
         bad_ff[wr_slot.slot]   <= ~is_digit;
      end
   end

   // The completing byte is the last digit, so it is merged in directly.
   always_comb begin
      push.valid                         = accept && done;
      push.rec.digits                    = digit_ff;
      push.rec.digits[NUM_DIGITS-1]      = digit_val;
      push.rec.all_digits                = ~(|bad_ff[NUM_DIGITS-2:0]) && is_digit;
      push.rec.seq_run                   = sequence_running;
   end

endmodule

[hw/rtl/slte_queue.sv]
// ---------------------------------------------------------------------------
// Status line time extractor capture queue
// Small register FIFO that decouples the matcher from the arithmetic.
// ---------------------------------------------------------------------------
module slte_queue import slte_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  rec_xfer_type push,
   input  logic         pop,
   output logic         full,
   output rec_xfer_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   rec_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head.valid = (count_ff != '0);
   assign head.rec   = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

[hw/rtl/slte_back.sv]
// ---------------------------------------------------------------------------
// Status line time extractor back end
// Three-stage arithmetic pipeline: digit pairs, times and events, media time.
// ---------------------------------------------------------------------------
module slte_back import slte_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rec_xfer_type head,
   output logic         pop,
   slte_csr_if.sink     csr,
   slte_rsp_if.source   rsp
);

   function automatic logic [HUNDREDTH_W-1:0] pair_value(input logic [3:0] hi,
                                                        input logic [3:0] lo);
      return HUNDREDTH_W'(HUNDREDTH_W'(hi) * 7'd10 + HUNDREDTH_W'(lo));
   endfunction

   logic sync_leader_ff;
   logic en;

   // Stage 1: two-digit values.
   logic                   s1_v_ff;
   logic [HUNDREDTH_W-1:0] em_ff, es_ff, eh_ff, rm_ff, rs_ff, rh_ff;
   logic                   s1_ok_ff, s1_seq_ff;

   // Stage 2: seconds, totals and event flags.
   logic                   s2_v_ff;
   logic [SECONDS_W-1:0]   el_ff, re_ff;
   logic [HUNDREDTH_W-1:0] s2_eh_ff, s2_rh_ff;
   logic [TMIN_W-1:0]      tmin_ff;
   logic [TSEC_W-1:0]      tsec_ff;
   logic                   sync_ff, adj_ff, s2_ok_ff;
   logic [SECONDS_W-1:0]   last_sync_ff, last_check_ff;

   logic [SECONDS_W-1:0]   el_in, re_in;
   logic [7:0]             ssum;
   logic [1:0]             carry;
   logic [7:0]             tsec_wide;
   logic                   sync_in, adj_in;

   // Output register.
   logic                   out_v_ff;
   logic [SECONDS_W-1:0]   o_el_ff, o_re_ff;
   logic [HUNDREDTH_W-1:0] o_eh_ff, o_rh_ff;
   logic [TMIN_W-1:0]      o_tmin_ff;
   logic [TSEC_W-1:0]      o_tsec_ff;
   logic [MEDIA_W-1:0]     o_media_ff;
   logic                   o_sync_ff, o_adj_ff, o_ok_ff;

   assign en        = !out_v_ff || rsp.ready;
   assign pop       = en && head.valid;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_leader_ff <= 1'b0;
      end else if (csr.valid) begin
         sync_leader_ff <= csr.sync_leader;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         em_ff     <= pair_value(head.rec.digits[0], head.rec.digits[1]);
         es_ff     <= pair_value(head.rec.digits[2], head.rec.digits[3]);
         eh_ff     <= pair_value(head.rec.digits[4], head.rec.digits[5]);
         rm_ff     <= pair_value(head.rec.digits[6], head.rec.digits[7]);
         rs_ff     <= pair_value(head.rec.digits[8], head.rec.digits[9]);
         rh_ff     <= pair_value(head.rec.digits[10], head.rec.digits[11]);
         s1_ok_ff  <= head.rec.all_digits;
         s1_seq_ff <= head.rec.seq_run;
      end
   end

   always_comb begin
      el_in = SECONDS_W'(SECONDS_W'(em_ff) * 13'd60 + SECONDS_W'(es_ff));
      re_in = SECONDS_W'(SECONDS_W'(rm_ff) * 13'd60 + SECONDS_W'(rs_ff));
      ssum  = 8'(es_ff) + 8'(rs_ff);
      // The seconds sum stays below 200, so the quotient by sixty is at most three.
      if (ssum >= 8'd180) begin
         carry     = 2'd3;
         tsec_wide = ssum - 8'd180;
      end else if (ssum >= 8'd120) begin
         carry     = 2'd2;
         tsec_wide = ssum - 8'd120;
      end else if (ssum >= 8'd60) begin
         carry     = 2'd1;
         tsec_wide = ssum - 8'd60;
      end else begin
         carry     = 2'd0;
         tsec_wide = ssum;
      end
      sync_in = sync_leader_ff && (el_in != '0) && (el_in != last_sync_ff);
      adj_in  = s1_seq_ff && (el_in != '0) && (el_in != last_check_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         el_ff    <= el_in;
         re_ff    <= re_in;
         s2_eh_ff <= eh_ff;
         s2_rh_ff <= rh_ff;
         tmin_ff  <= TMIN_W'(em_ff) + TMIN_W'(rm_ff) + TMIN_W'(carry);
         tsec_ff  <= tsec_wide[TSEC_W-1:0];
         sync_ff  <= sync_in;
         adj_ff   <= adj_in;
         s2_ok_ff <= s1_ok_ff;
      end
   end

   // Each last-second register moves only for a flagged result, as it enters stage 2.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_sync_ff  <= '0;
         last_check_ff <= '0;
      end else if (en && s1_v_ff) begin
         if (sync_in) begin
            last_sync_ff <= el_in;
         end
         if (adj_in) begin
            last_check_ff <= el_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_el_ff    <= el_ff;
         o_re_ff    <= re_ff;
         o_eh_ff    <= s2_eh_ff;
         o_rh_ff    <= s2_rh_ff;
         o_tmin_ff  <= tmin_ff;
         o_tsec_ff  <= tsec_ff;
         o_media_ff <= MEDIA_W'(MEDIA_W'(el_ff) * 20'd100 + MEDIA_W'(s2_eh_ff));
         o_sync_ff  <= sync_ff;
         o_adj_ff   <= adj_ff;
         o_ok_ff    <= s2_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff  <= head.valid;
         s2_v_ff  <= s1_v_ff;
         out_v_ff <= s2_v_ff;
      end
   end

   assign rsp.valid                 = out_v_ff;
   assign rsp.elapsed_seconds       = o_el_ff;
   assign rsp.elapsed_hundredths    = o_eh_ff;
   assign rsp.remaining_seconds     = o_re_ff;
   assign rsp.remaining_hundredths  = o_rh_ff;
   assign rsp.total_minutes         = o_tmin_ff;
   assign rsp.total_seconds         = o_tsec_ff;
   assign rsp.media_time_hundredths = o_media_ff;
   assign rsp.send_sync             = o_sync_ff;
   assign rsp.adjust_delay          = o_adj_ff;
   assign rsp.digits_ok             = o_ok_ff;

endmodule

[hw/rtl/status_line_time_extractor.sv]
// ---------------------------------------------------------------------------
// Status line time extractor
// Data path: the byte completing a capture is written to the queue, and the
// result then passes the pair stage, time stage and output register.
// Throughput: one byte per cycle; at most one result per cycle, limited by
// the output handshake. Bytes stall only while the capture queue is full.
// Reset (synchronous, active high) returns the matcher to idle, empties the
// queue and pipeline, and clears the sync mode and both last-second registers.
// ---------------------------------------------------------------------------
module status_line_time_extractor import slte_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input logic         clock,
   input logic         reset,
   slte_req_if.sink    req_bus,
   slte_rsp_if.source  rsp_bus,
   slte_csr_if.sink    csr_bus
);

   rec_xfer_type push, head;
   logic         q_full, pop, accept;

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && req_bus.ready;

   slte_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .data_byte        (req_bus.data_byte),
      .last_of_chunk    (req_bus.last_of_chunk),
      .sequence_running (req_bus.sequence_running),
      .push             (push)
   );

   slte_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   slte_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .csr   (csr_bus),
      .rsp   (rsp_bus)
   );

   // A completed capture must never be dropped at the queue.
   assert property (@(posedge clock) disable iff (reset) push.valid |-> !q_full)
      else $error("capture pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.send_sync || rsp_bus.adjust_delay))
         |-> (rsp_bus.elapsed_seconds != '0))
      else $error("event flag raised for zero elapsed time");

   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.total_seconds < TSEC_W'(60)))
      else $error("total seconds out of range");

   assert property (@(posedge clock) $past(reset) |-> !rsp_bus.valid)
      else $error("result valid right after reset");

endmodule
